// ===== hdl/rotenc_pkg.sv =====
// Shared types and constants for the rotary encoder event decoder.
// No dependencies; imported by every module of the block.
package rotenc_pkg;

  // turn count width and the amount one detent adds
  localparam int unsigned CountWidth = 16;
  localparam logic [CountWidth-1:0] TurnStep = CountWidth'(5);

  // configuration register widths
  localparam int unsigned ThreshWidth   = 16;
  localparam int unsigned DebWidth      = 8;
  localparam int unsigned HoldWidth     = 16;
  localparam int unsigned UnitsWidth    = 5;
  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 16;

  // configuration register indexes
  localparam logic [CfgIndexWidth-1:0] RegFastThreshold = 2'd0;
  localparam logic [CfgIndexWidth-1:0] RegDebounceTicks = 2'd1;
  localparam logic [CfgIndexWidth-1:0] RegHoldUnitTicks = 2'd2;
  localparam logic [CfgIndexWidth-1:0] RegLongUnits     = 2'd3;

  // configuration reset values
  localparam logic [ThreshWidth-1:0] FastThresholdRst = 16'd10;
  localparam logic [DebWidth-1:0]    DebounceTicksRst = 8'd5;
  localparam logic [HoldWidth-1:0]   HoldUnitTicksRst = 16'd100;
  localparam logic [UnitsWidth-1:0]  LongUnitsRst     = 5'd30;

  // event codes reported to the reader
  typedef enum logic [2:0] {
    EvIdle      = 3'd0,
    EvLeft      = 3'd1,
    EvRight     = 3'd2,
    EvLeftFast  = 3'd3,
    EvRightFast = 3'd4,
    EvShort     = 3'd5,
    EvLong      = 3'd6,
    EvHeld      = 3'd7
  } event_e;

  // confirmed turns from the encoder tracker
  typedef struct packed {
    logic left;
    logic right;
  } enc_evt_t;

  // button timing settings
  typedef struct packed {
    logic [DebWidth-1:0]   debounce_ticks;
    logic [HoldWidth-1:0]  hold_unit_ticks;
    logic [UnitsWidth-1:0] long_press_units;
  } btn_cfg_t;

  // event raised by the button timer
  typedef struct packed {
    logic   valid;
    event_e code;
  } btn_evt_t;

endpackage

// ===== hdl/rotenc_encoder.sv =====
// Quadrature tracker: arms a direction on falling A, confirms it on rising A.
// Holds the left and right turn counts. Depends on rotenc_pkg.
module rotenc_encoder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             step_i,
  input  logic                             level_a_i,
  input  logic                             level_b_i,
  input  logic                             clear_counts_i,
  output rotenc_pkg::enc_evt_t             evt_o,
  output logic [rotenc_pkg::CountWidth-1:0] left_count_next_o,
  output logic [rotenc_pkg::CountWidth-1:0] right_count_next_o
);
  import rotenc_pkg::*;

  logic                  prev_a_q, prev_a_d;
  logic                  left_arm_q, left_arm_d;
  logic                  right_arm_q, right_arm_d;
  logic [CountWidth-1:0] left_cnt_q, left_cnt_d;
  logic [CountWidth-1:0] right_cnt_q, right_cnt_d;
  logic [CountWidth-1:0] left_next, right_next;
  enc_evt_t              evt;

  // edge detection and direction confirmation
  always_comb begin
    prev_a_d    = prev_a_q;
    left_arm_d  = left_arm_q;
    right_arm_d = right_arm_q;
    left_next   = left_cnt_q;
    right_next  = right_cnt_q;
    evt         = '0;
    if (level_a_i != prev_a_q) begin
      prev_a_d = level_a_i;
      if (!level_a_i) begin
        if (!level_b_i) begin
          left_arm_d = 1'b1;
        end else begin
          right_arm_d = 1'b1;
        end
      end else begin
        if (level_b_i) begin
          if (left_arm_q) begin
            left_next = left_cnt_q + TurnStep;
            evt.left  = 1'b1;
          end
        end else begin
          if (right_arm_q) begin
            right_next = right_cnt_q + TurnStep;
            evt.right  = 1'b1;
          end
        end
        left_arm_d  = 1'b0;
        right_arm_d = 1'b0;
      end
    end
    left_cnt_d  = clear_counts_i ? '0 : left_next;
    right_cnt_d = clear_counts_i ? '0 : right_next;
  end

  assign evt_o              = step_i ? evt : '0;
  assign left_count_next_o  = left_next;
  assign right_count_next_o = right_next;

  // state update once per accepted sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_a_q    <= 1'b1;
      left_arm_q  <= 1'b0;
      right_arm_q <= 1'b0;
      left_cnt_q  <= '0;
      right_cnt_q <= '0;
    end else if (step_i) begin
      prev_a_q    <= prev_a_d;
      left_arm_q  <= left_arm_d;
      right_arm_q <= right_arm_d;
      left_cnt_q  <= left_cnt_d;
      right_cnt_q <= right_cnt_d;
    end
  end

`ifndef ASSERT_OFF
  // only one falling edge of A can come before the next rising edge
  a_one_arm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(left_arm_q && right_arm_q))
    else $error("both turn directions armed");
`endif

endmodule

// ===== hdl/rotenc_button.sv =====
// Push button debounce and hold timer producing HELD, SHORT and LONG events.
// Depends on rotenc_pkg.
module rotenc_button (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 button_level_i,
  input  rotenc_pkg::btn_cfg_t cfg_i,
  output rotenc_pkg::btn_evt_t evt_o
);
  import rotenc_pkg::*;

  typedef enum logic [1:0] {
    PhReleased = 2'd0,
    PhDebounce = 2'd1,
    PhHold     = 2'd2
  } phase_e;

  phase_e                phase_q, phase_d;
  logic [HoldWidth-1:0]  timer_q, timer_d;
  logic [UnitsWidth-1:0] units_q, units_d;
  logic                  pressed;
  logic [HoldWidth:0]    timer_inc;
  logic [HoldWidth:0]    unit_len;
  logic [HoldWidth-1:0]  deb_ext;
  btn_evt_t              evt;

  assign pressed   = !button_level_i;
  assign timer_inc = {1'b0, timer_q} + (HoldWidth+1)'(1);
  assign unit_len  = {1'b0, cfg_i.hold_unit_ticks};
  assign deb_ext   = HoldWidth'(cfg_i.debounce_ticks);

  // phase transitions for one sample
  always_comb begin
    phase_d = phase_q;
    timer_d = timer_q;
    units_d = units_q;
    evt     = '{valid: 1'b0, code: EvIdle};
    unique case (phase_q)
      PhDebounce: begin
        if (!pressed) begin
          phase_d = PhReleased;
          timer_d = '0;
        end else begin
          timer_d = timer_inc[HoldWidth-1:0];
          if (timer_inc[HoldWidth-1:0] >= deb_ext) begin
            phase_d = PhHold;
            timer_d = '0;
            units_d = '0;
          end
        end
      end
      PhHold: begin
        if (timer_inc < unit_len) begin
          timer_d = timer_inc[HoldWidth-1:0];
        end else begin
          // end of a hold unit
          timer_d   = '0;
          evt.valid = 1'b1;
          evt.code  = EvHeld;
          if (units_q < cfg_i.long_press_units) begin
            units_d = units_q + UnitsWidth'(1);
          end else begin
            evt.code = EvLong;
          end
          if (!pressed) begin
            evt.code = (units_d >= cfg_i.long_press_units) ? EvLong : EvShort;
            phase_d  = PhReleased;
          end
        end
      end
      default: begin
        phase_d = PhReleased;
        timer_d = '0;
        if (pressed) begin
          timer_d = HoldWidth'(1);
          if (HoldWidth'(1) >= deb_ext) begin
            phase_d = PhHold;
            timer_d = '0;
            units_d = '0;
          end else begin
            phase_d = PhDebounce;
          end
        end
      end
    endcase
  end

  assign evt_o = step_i ? evt : '{valid: 1'b0, code: EvIdle};

  // phase and timers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhReleased;
      timer_q <= '0;
      units_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      timer_q <= timer_d;
      units_q <= units_d;
    end
  end

endmodule

// ===== hdl/rotary_encoder_event_decoder.sv =====
// Top level of the rotary encoder event decoder: configuration registers,
// pending event, read handling and the result register.
// Depends on rotenc_pkg, rotenc_encoder and rotenc_button.
// Usage:
//   s_axis carries one pin sample per transaction: levels of A, B and the
//   button (all active low) plus a read request and a fast check flag.
//   Every accepted sample yields exactly one result on m_axis: tdata holds
//   the event code and tuser is set when the result answers a read.
//   A read returns the pending event and clears it; with fast check a count at or
//   above the threshold first becomes a fast event (right wins) and both are zeroed.
//   The cfg channel writes one register per transaction and is always ready;
//   write only while no sample is in flight.
// Result and throughput:
//   the result is registered and appears in the cycle after its sample is
//   accepted; one sample is taken every cycle, limited only by the single result register.
// Reset:
//   clears all tracking state, the pending event and the result valid flag and
//   restores default settings (threshold 10, debounce 5, unit 100, long 30).
// Stall:
//   while a result waits on m_axis_tready_i, s_axis_tready_o stays low.
module rotary_encoder_event_decoder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // sample channel
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [0] level_a, [1] level_b, [2] button_level, [3] read_request,
  // [4] fast_check, [7:5] zero
  input  logic [7:0]                          s_axis_tdata_i,
  // result channel
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [2:0] event_code, [7:3] zero
  output logic [7:0]                          m_axis_tdata_o,
  // [0] read_done
  output logic                                m_axis_tuser_o,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rotenc_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  logic [rotenc_pkg::CfgDataWidth-1:0]  cfg_data_i
);
  import rotenc_pkg::*;

  localparam int unsigned CmpWidth = (CountWidth > ThreshWidth) ? CountWidth : ThreshWidth;

  logic [ThreshWidth-1:0] thresh_q;
  btn_cfg_t               btn_cfg_q;
  event_e                 pending_q, pending_d;
  logic                   out_valid_q;
  event_e                 out_code_q, out_code_d;
  logic                   out_done_q;

  logic                  accept;
  logic                  level_a, level_b, button_level, read_req, fast_chk;
  logic                  clear_counts;
  enc_evt_t              enc_evt;
  btn_evt_t              btn_evt;
  logic [CountWidth-1:0] left_next, right_next;
  event_e                merged;
  logic                  left_fast, right_fast;

  assign level_a      = s_axis_tdata_i[0];
  assign level_b      = s_axis_tdata_i[1];
  assign button_level = s_axis_tdata_i[2];
  assign read_req     = s_axis_tdata_i[3];
  assign fast_chk     = s_axis_tdata_i[4];

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign clear_counts    = read_req && fast_chk;

  rotenc_encoder u_encoder (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .step_i             (accept),
    .level_a_i          (level_a),
    .level_b_i          (level_b),
    .clear_counts_i     (clear_counts),
    .evt_o              (enc_evt),
    .left_count_next_o  (left_next),
    .right_count_next_o (right_next)
  );

  rotenc_button u_button (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (accept),
    .button_level_i (button_level),
    .cfg_i          (btn_cfg_q),
    .evt_o          (btn_evt)
  );

  assign left_fast  = CmpWidth'(left_next) >= CmpWidth'(thresh_q);
  assign right_fast = CmpWidth'(right_next) >= CmpWidth'(thresh_q);

  // pending event: encoder first, then button, then read
  always_comb begin
    merged = pending_q;
    if (enc_evt.left) begin
      merged = EvLeft;
    end else if (enc_evt.right) begin
      merged = EvRight;
    end
    if (btn_evt.valid) begin
      merged = btn_evt.code;
    end
    if (clear_counts) begin
      priority if (right_fast) begin
        merged = EvRightFast;
      end else if (left_fast) begin
        merged = EvLeftFast;
      end else begin
        // neither count reaches the threshold: keep the event
      end
    end
    if (read_req) begin
      out_code_d = merged;
      pending_d  = EvIdle;
    end else begin
      out_code_d = EvIdle;
      pending_d  = merged;
    end
  end

  // pending event and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= EvIdle;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        pending_q   <= pending_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_code_q <= out_code_d;
      out_done_q <= read_req;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_code_q};
  assign m_axis_tuser_o  = out_done_q;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q                   <= FastThresholdRst;
      btn_cfg_q.debounce_ticks   <= DebounceTicksRst;
      btn_cfg_q.hold_unit_ticks  <= HoldUnitTicksRst;
      btn_cfg_q.long_press_units <= LongUnitsRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegFastThreshold: thresh_q <= cfg_data_i[ThreshWidth-1:0];
        RegDebounceTicks: btn_cfg_q.debounce_ticks <= cfg_data_i[DebWidth-1:0];
        RegHoldUnitTicks: btn_cfg_q.hold_unit_ticks <= cfg_data_i[HoldWidth-1:0];
        RegLongUnits:     btn_cfg_q.long_press_units <= cfg_data_i[UnitsWidth-1:0];
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // every accepted sample leaves a result in the output register
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid_o)
    else $error("accepted sample produced no result");

  // a result that answers no read carries the idle code
  a_idle_without_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o == 8'(EvIdle)))
    else $error("event reported without a read");

  // fast events arise only inside a read and never stay pending
  a_no_pending_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pending_q != EvLeftFast) && (pending_q != EvRightFast))
    else $error("fast event left pending");
`endif

endmodule
